@@ hw/rtl/ims_pkg.sv @@
// shared constants and a helper function for the interval merge set
package ims_pkg;
    localparam int SLOTS_DEFAULT = 16;
    localparam int VAL_W = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;  // unused code, reports count and total only

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // a <= b + 1 with one extra bit
    function automatic logic le_next(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        le_next = ({1'b0, a} <= ({1'b0, b} + {{VAL_W{1'b0}}, 1'b1}));
    endfunction
endpackage

@@ hw/rtl/interval_merge_set.sv @@
// top level of the interval merge set
// steps from the accepting edge to out_valid: insert runs merge passes over the slots,
//   repeated until one absorbs nothing, then writes the merged range
//   (no write on a full table); pop runs a min search over the slots; clear and unused commands go straight to done
// flow: one item at a time, the next item is taken only after the result is taken
// reset: asynchronous active low, valid bits, count and sum cleared at once,
//   range memory contents left undefined (read only through a valid bit)
module interval_merge_set #(
    parameter int SLOTS = ims_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [63:0] range_start,
    input  logic [63:0] range_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] out_start,
    output logic [63:0] out_end,
    output logic [4:0]  entry_count,
    output logic [63:0] covered_total
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // merge pass over slots
    localparam logic [2:0] S_WRITE = 3'd2;  // store merged range
    localparam logic [2:0] S_POP   = 3'd3;  // min search
    localparam logic [2:0] S_DONE  = 3'd4;  // result waits

    logic [2:0]       state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [63:0]      sum_reg, sum_next;
    logic [63:0]      s_reg, s_next, e_reg, e_next;
    logic [1:0]       status_reg, status_next;
    logic [IW:0]      idx_reg, idx_next;      // issue pointer, one ahead of data
    logic             changed_reg, changed_next;
    logic             hit_reg, hit_next;      // any pass of this insert absorbed anything
    logic             found_reg, found_next;
    logic [IW-1:0]    best_reg, best_next;
    logic [63:0]      bs_reg, bs_next, be_reg, be_next;
    logic             cmp_ok_reg, cmp_ok_next;   // previous issue valid
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;

    logic          we;
    logic [IW-1:0] addr;
    logic [63:0]   rs, re;
    logic [IW-1:0] free_idx;

    ims_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_starts (
        .clk(clk), .we(we), .addr(addr), .wdata(s_reg), .rdata(rs));
    ims_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_ends (
        .clk(clk), .we(we), .addr(addr), .wdata(e_reg), .rdata(re));

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign in_ready      = (state_reg == S_IDLE) && !out_valid;
    assign out_valid     = (state_reg == S_DONE);
    assign status        = status_reg;
    assign out_start     = s_reg;
    assign out_end       = e_reg;
    assign entry_count   = 5'(count_reg);
    assign covered_total = sum_reg;

    always_comb
    begin
        logic ov;
        state_next   = state_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        status_next  = status_reg;
        idx_next     = idx_reg;
        changed_next = changed_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        bs_next      = bs_reg;
        be_next      = be_reg;
        cmp_ok_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        we           = 1'b0;
        addr         = idx_reg[IW-1:0];
        ov = ims_pkg::le_next(s_reg, re) && ims_pkg::le_next(rs, e_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                    hit_next     = 1'b0;
                    found_next   = 1'b0;
                    status_next  = ims_pkg::ST_OK;
                    unique case (cmd)
                        ims_pkg::CMD_INSERT:
                        begin
                            s_next     = range_start;
                            e_next     = range_end;
                            state_next = S_SCAN;
                        end
                        ims_pkg::CMD_POP:
                        begin
                            state_next = S_POP;
                        end
                        ims_pkg::CMD_CLEAR:
                        begin
                            valid_next = '0;
                            count_next = '0;
                            sum_next   = '0;
                            s_next     = '0;
                            e_next     = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            s_next     = '0;
                            e_next     = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // evaluate slot read last cycle
                if (cmp_ok_reg && valid_reg[rd_idx_reg] && ov)
                begin
                    if (rs < s_reg) s_next = rs;
                    if (re > e_reg) e_next = re;
                    valid_next[rd_idx_reg] = 1'b0;
                    count_next   = count_reg - CW'(1);
                    sum_next     = sum_reg - (re - rs);
                    changed_next = 1'b1;
                    hit_next     = 1'b1;
                end
                if (idx_reg < (IW+1)'(SLOTS))
                begin
                    cmp_ok_next = 1'b1;
                    rd_idx_next = idx_reg[IW-1:0];
                    idx_next    = idx_reg + (IW+1)'(1);
                end
                else if (changed_next)
                begin
                    // a merge widened the range: another pass
                    changed_next = 1'b0;
                    idx_next     = '0;
                end
                else if (!hit_next && (count_reg == CW'(SLOTS)))
                begin
                    status_next = ims_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                we    = 1'b1;
                addr  = free_idx;
                valid_next[free_idx] = 1'b1;
                count_next = count_reg + CW'(1);
                sum_next   = sum_reg + (e_reg - s_reg);
                state_next = S_DONE;
            end
            S_POP:
            begin
                if (cmp_ok_reg && valid_reg[rd_idx_reg] && (!found_reg || rs < bs_reg))
                begin
                    found_next = 1'b1;
                    best_next  = rd_idx_reg;
                    bs_next    = rs;
                    be_next    = re;
                end
                if (idx_reg < (IW+1)'(SLOTS))
                begin
                    cmp_ok_next = 1'b1;
                    rd_idx_next = idx_reg[IW-1:0];
                    idx_next    = idx_reg + (IW+1)'(1);
                end
                else
                begin
                    state_next = S_DONE;
                    if (found_next)
                    begin
                        s_next = bs_next;
                        e_next = be_next;
                        valid_next[best_next] = 1'b0;
                        count_next = count_reg - CW'(1);
                        sum_next   = sum_reg - (be_next - bs_next);
                    end
                    else
                    begin
                        s_next      = '0;
                        e_next      = '0;
                        status_next = ims_pkg::ST_EMPTY;
                    end
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            cmp_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            cmp_ok_reg  <= cmp_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        e_reg       <= e_next;
        status_reg  <= status_next;
        idx_reg     <= idx_next;
        changed_reg <= changed_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        bs_reg      <= bs_next;
        be_reg      <= be_next;
        rd_idx_reg  <= rd_idx_next;
    end
endmodule

@@ hw/rtl/ims_ram.sv @@
// generic single port ram with registered read
module ims_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
